// ----- rtl/core/clq_pkg.sv -----
// Shared constants, codes and link store request and response types for the circular queue manager.
package clq_pkg;

	localparam int ELEMENTS_DEF = 64;
	localparam int ELEM_W       = 6;
	localparam int SIZE_W       = 7;
	localparam int STATUS_W     = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_LINKED     = 2'd1,
		ST_EMPTY      = 2'd2,
		ST_NOT_MEMBER = 2'd3
	} status_t;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              nx_we;
		logic [ELEM_W-1:0] nx_waddr;
		logic [ELEM_W-1:0] nx_wdata;
		logic              pv_we;
		logic [ELEM_W-1:0] pv_waddr;
		logic [ELEM_W-1:0] pv_wdata;
		logic [ELEM_W-1:0] nx_raddr;
		logic [ELEM_W-1:0] pv_raddr;
	} link_req_t;

	typedef struct packed {
		logic [ELEM_W-1:0] nx_rdata;
		logic [ELEM_W-1:0] pv_rdata;
	} link_rsp_t;

endpackage

// ----- rtl/core/clq_req_if.sv -----
// Request channel carrying one command item per handshake.
interface clq_req_if import clq_pkg::*; ();

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [ELEM_W-1:0] elem;

	modport source(output valid, cmd, elem, input ready);
	modport sink(input valid, cmd, elem, output ready);

endinterface

// ----- rtl/core/clq_rsp_if.sv -----
// Response channel carrying one result item per handshake.
interface clq_rsp_if import clq_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SIZE_W-1:0]   size;
	logic [ELEM_W-1:0]   head;
	logic                head_valid;

	modport source(output valid, status, size, head, head_valid, input ready);
	modport sink(input valid, status, size, head, head_valid, output ready);

endinterface

// ----- rtl/core/clq_links.sv -----
// Next and prev link memories, one write and one registered read port each.
module clq_links import clq_pkg::*; #(
	parameter int POOL = ELEMENTS_DEF,
	parameter int IW   = $clog2(POOL)
) (
	input  logic      clk,
	input  link_req_t lreq,
	output link_rsp_t lrsp
);

	logic [IW-1:0] nx_mem [POOL];
	logic [IW-1:0] pv_mem [POOL];

	always_ff @(posedge clk) begin
		if (lreq.nx_we) begin
			nx_mem[IW'(lreq.nx_waddr)] <= IW'(lreq.nx_wdata);
		end
		if (lreq.pv_we) begin
			pv_mem[IW'(lreq.pv_waddr)] <= IW'(lreq.pv_wdata);
		end
		lrsp.nx_rdata <= ELEM_W'(nx_mem[IW'(lreq.nx_raddr)]);
		lrsp.pv_rdata <= ELEM_W'(pv_mem[IW'(lreq.pv_raddr)]);
	end

endmodule

// ----- rtl/core/clq_ctrl.sv -----
// Sequencer that checks flags, walks the link store and keeps head and count.
module clq_ctrl import clq_pkg::*; #(
	parameter int POOL = ELEMENTS_DEF,
	parameter int IW   = $clog2(POOL)
) (
	input  logic       clk,
	input  logic       arst_n,
	clq_req_if.sink    req,
	clq_rsp_if.source  rsp,
	output link_req_t  lreq,
	input  link_rsp_t  lrsp
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CHECK  = 6'b000010,
		S_TAIL   = 6'b000100,
		S_LINK   = 6'b001000,
		S_UNLINK = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [IW-1:0]       elem_q;
	logic                pool_q;
	logic [IW-1:0]       tail_q;
	status_t             status_q;
	logic [IW-1:0]       head_q;
	logic [SIZE_W-1:0]   count_q;
	logic [POOL-1:0]     flag_q;
	logic                rvalid_q;
	status_t             rstatus_q;
	logic [SIZE_W-1:0]   rsize_q;
	logic [ELEM_W-1:0]   rhead_q;
	logic                rhv_q;

	logic                is_linked;
	logic                first;
	logic                last;
	logic                out_free;
	status_t             chk_status;
	logic [SIZE_W-1:0]   count_sum;
	logic [IW-1:0]       nx;
	logic [IW-1:0]       pv;

	assign is_linked = pool_q && flag_q[elem_q];
	assign first     = (count_q == '0);
	assign last      = (count_q == SIZE_W'(1));
	assign out_free  = !rvalid_q || rsp.ready;
	assign nx        = IW'(lrsp.nx_rdata);
	assign pv        = IW'(lrsp.pv_rdata);

	// The one count adder steps up on a link and down on an unlink.
	assign count_sum = count_q + ((state_q == S_UNLINK) ? {SIZE_W{1'b1}} : SIZE_W'(1));

	always_comb begin
		chk_status = ST_OK;
		if (cmd_q == CMD_APPEND) begin
			if (!pool_q || is_linked) begin
				chk_status = ST_LINKED;
			end
		end else if (first) begin
			chk_status = ST_EMPTY;
		end else if (!is_linked) begin
			chk_status = ST_NOT_MEMBER;
		end
	end

	always_comb begin
		lreq = '0;
		case (state_q)
			S_CHECK: begin
				if (cmd_q == CMD_APPEND) begin
					lreq.pv_raddr = ELEM_W'(head_q);
					if (chk_status == ST_OK && first) begin
						lreq.nx_we    = 1'b1;
						lreq.nx_waddr = ELEM_W'(elem_q);
						lreq.nx_wdata = ELEM_W'(elem_q);
						lreq.pv_we    = 1'b1;
						lreq.pv_waddr = ELEM_W'(elem_q);
						lreq.pv_wdata = ELEM_W'(elem_q);
					end
				end else begin
					lreq.nx_raddr = ELEM_W'(elem_q);
					lreq.pv_raddr = ELEM_W'(elem_q);
				end
			end
			S_TAIL: begin
				lreq.nx_we    = 1'b1;
				lreq.nx_waddr = ELEM_W'(elem_q);
				lreq.nx_wdata = ELEM_W'(head_q);
				lreq.pv_we    = 1'b1;
				lreq.pv_waddr = ELEM_W'(elem_q);
				lreq.pv_wdata = lrsp.pv_rdata;
			end
			S_LINK: begin
				lreq.pv_we    = 1'b1;
				lreq.pv_waddr = ELEM_W'(head_q);
				lreq.pv_wdata = ELEM_W'(elem_q);
				lreq.nx_we    = 1'b1;
				lreq.nx_waddr = ELEM_W'(tail_q);
				lreq.nx_wdata = ELEM_W'(elem_q);
			end
			S_UNLINK: begin
				if (!(nx == elem_q || last)) begin
					lreq.nx_we    = 1'b1;
					lreq.nx_waddr = ELEM_W'(pv);
					lreq.nx_wdata = ELEM_W'(nx);
					lreq.pv_we    = 1'b1;
					lreq.pv_waddr = ELEM_W'(nx);
					lreq.pv_wdata = ELEM_W'(pv);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			flag_q   <= '0;
			head_q   <= '0;
			count_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (state_q == S_RESULT && out_free) begin
				rvalid_q <= 1'b1;
			end else if (rsp.ready) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (chk_status != ST_OK) begin
						state_q <= S_RESULT;
					end else if (cmd_q == CMD_REMOVE) begin
						state_q <= S_UNLINK;
					end else if (first) begin
						flag_q[elem_q] <= 1'b1;
						head_q         <= elem_q;
						count_q        <= count_sum;
						state_q        <= S_RESULT;
					end else begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					flag_q[elem_q] <= 1'b1;
					count_q        <= count_sum;
					state_q        <= S_RESULT;
				end
				S_UNLINK: begin
					flag_q[elem_q] <= 1'b0;
					if (nx == elem_q || last) begin
						head_q  <= '0;
						count_q <= '0;
					end else begin
						count_q <= count_sum;
						if (head_q == elem_q) begin
							head_q <= nx;
						end
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q  <= cmd_t'(req.cmd);
			elem_q <= IW'(req.elem);
			pool_q <= (32'(req.elem) < 32'(POOL));
		end
		if (state_q == S_CHECK) begin
			status_q <= chk_status;
		end
		if (state_q == S_TAIL) begin
			tail_q <= pv;
		end
		if (state_q == S_RESULT && out_free) begin
			rstatus_q <= status_q;
			rsize_q   <= count_q;
			rhead_q   <= ELEM_W'(head_q);
			rhv_q     <= !first;
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rvalid_q;
	assign rsp.status     = rstatus_q;
	assign rsp.size       = rsize_q;
	assign rsp.head       = rhead_q;
	assign rsp.head_valid = rhv_q;

endmodule

// ----- rtl/core/circular_linked_queue_manager.sv -----
// Top level of the circular doubly linked queue manager.
//
// The block keeps one circular doubly linked queue over a pool of numbered
// elements. Each request item carries a command (append at tail or remove)
// and an element number; each request yields exactly one response item with
// a status code, the queue size, the head element and a head valid flag.
// Both channels use a valid and ready handshake.
// An append to an empty queue and every failing command go from the check
// step straight to the result step, an append to a nonempty queue passes
// through the tail and link steps and a remove of a member through the
// unlink step. The next request is accepted once the sequencer is back in
// idle. The sequencer and the single read and write port of each link
// memory set these steps; the block holds one request at a time, and
// ready is high only while idle.
// The response register holds a finished item until it is taken, so a new
// request is accepted while the receiver stalls; that request then waits in
// its last step until the register frees.
// Reset empties the queue at once, with all elements unlinked and the head
// at zero; the link memories are not cleared and need no clearing pass.
module circular_linked_queue_manager import clq_pkg::*; #(
	parameter int ELEMENTS = ELEMENTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	clq_req_if.sink   req,
	clq_rsp_if.source rsp
);

	localparam int POOL = (ELEMENTS < (1 << ELEM_W)) ? ELEMENTS : (1 << ELEM_W);
	localparam int IW   = $clog2(POOL);

	link_req_t lreq;
	link_rsp_t lrsp;

	clq_ctrl #(
		.POOL(POOL),
		.IW  (IW)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.lreq  (lreq),
		.lrsp  (lrsp)
	);

	clq_links #(
		.POOL(POOL),
		.IW  (IW)
	) u_links (
		.clk (clk),
		.lreq(lreq),
		.lrsp(lrsp)
	);

	a_head_valid_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.head_valid == (rsp.size != '0)))
		else $error("Head valid flag disagrees with the queue size.");

	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.head_valid) |-> (rsp.head == '0))
		else $error("Empty queue reports a nonzero head.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("Request accepted while an item is still in work.");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.size <= SIZE_W'(POOL)))
		else $error("Queue size exceeds the element pool.");

endmodule
